// ----- hdl/glj_pkg.sv -----
// Package for the greedy line justifier: character codes, widths and the
// emitter state type. No dependencies.
`default_nettype none
package glj_pkg;
  localparam logic [7:0] SpaceCh   = 8'd32;
  localparam logic [7:0] HyphenCh  = 8'd45;
  localparam logic [7:0] NewlineCh = 8'd10;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned CntW     = 6;
  localparam logic [4:0] RegWidth  = 5'd0;

  typedef enum logic [3:0] {
    StIdle,
    StScanRd,
    StScan,
    StPlan,
    StEmitRd,
    StEmit,
    StPad,
    StNewline,
    StMoveRd,
    StMove,
    StFlushRd,
    StFlush
  } state_e;

  // How the current line is laid out.
  typedef enum logic [1:0] {
    ModePlain,
    ModeHyphen,
    ModeJustify
  } mode_e;
endpackage
`default_nettype wire

// ----- hdl/glj_if.sv -----
// Valid/ready stream interfaces for input and result items.
// Depends on nothing.
`default_nettype none
interface glj_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       para_end;
  modport source (output valid, in_char, para_end, input ready);
  modport sink (input valid, in_char, para_end, output ready);
endinterface

interface glj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       para_done;
  modport source (output valid, out_char, run_last, para_done, input ready);
  modport sink (input valid, out_char, run_last, para_done, output ready);
endinterface
`default_nettype wire

// ----- hdl/glj_store.sv -----
// Line store: 32 x 8 synchronous memory with one write and one registered read.
// Depends on glj_pkg.
`default_nettype none
module glj_store (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [glj_pkg::AddrW-1:0] waddr_i,
  input  wire logic [7:0]               wdata_i,
  input  wire logic [glj_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);
  logic [7:0] mem_q [2**glj_pkg::AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/glj_divider.sv -----
// Restoring divider for extra / gaps, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module glj_divider (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [5:0] num_i,
  input  wire logic [4:0] den_i,
  output logic            busy_o,
  output logic [5:0]      quo_o,
  output logic [4:0]      rem_o
);
  logic [2:0] cnt_q;
  logic [5:0] quo_q;
  logic [5:0] rem_q;
  logic [4:0] den_q;
  logic [6:0] trial;

  assign trial  = {rem_q, quo_q[5]} - {2'b0, den_q};
  assign busy_o = cnt_q != 3'd0;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[4:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (start_i) begin
      cnt_q <= 3'd6;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= 6'd0;
      den_q <= den_i;
    end else if (busy_o) begin
      if (!trial[6]) begin
        rem_q <= trial[5:0];
        quo_q <= {quo_q[4:0], 1'b1};
      end else begin
        rem_q <= {rem_q[4:0], quo_q[5]};
        quo_q <= {quo_q[4:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/greedy_line_justifier.sv -----
// Top level of the greedy line justifier: APB register, sequencer around the
// line store memory and the gap divider. Depends on glj_pkg, glj_if, glj_store,
// glj_divider.
//
//   channel  | direction | handshake    | payload
//   in_s     | sink      | valid/ready  | in_char, para_end
//   out_m    | source    | valid/ready  | out_char, run_last, para_done
//   apb      | sink      | psel/penable | target_width at address 0
//
// One item at a time. A character that completes no line is taken and the next
// can follow at once. A line is scanned, then planned (waiting on the divider
// when gaps are widened), then its source characters are emitted with padding
// spaces at each gap, then a closing step, a hyphen if hyphenated and a newline,
// and then the kept characters are moved forward. A paragraph end flushes every
// held character. A stalled output stalls the sequencer while it emits. Reset
// is asynchronous and clears all control state; the store needs no clearing.
`default_nettype none
module greedy_line_justifier #(
  parameter int unsigned MaxLine = 31
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  glj_in_if.sink    in_s,
  glj_out_if.source out_m,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam logic [4:0] MaxW = 5'(MaxLine);
  localparam logic [4:0] RegWidth = glj_pkg::RegWidth;

  logic [4:0] width_q;
  logic       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == RegWidth[0:0]) &&
                  (paddr[1:0] == 2'b00);
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, width_q} : 32'd0;

  // Width in use: the register saturated to the range 2 to MaxLine.
  logic [4:0] w;
  always_comb begin
    w = width_q;
    if (w < 5'd2) w = 5'd2;
    if (w > MaxW) w = MaxW;
  end

  glj_pkg::state_e state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic       end_q, end_d;
  logic [5:0] idx_q, idx_d;      // walk pointer
  logic [5:0] dst_q, dst_d;      // move destination / pad counter
  logic [4:0] spaces_q, spaces_d;
  logic [4:0] last_q, last_d;
  glj_pkg::mode_e mode_q, mode_d;
  logic [5:0] used_q, used_d;
  logic [5:0] qcnt_q, qcnt_d;
  logic [4:0] rcnt_q, rcnt_d;

  // Output register.
  logic       ov_q;
  logic [7:0] oc_q;
  logic       ol_q, od_q;
  logic       emit;
  logic [7:0] emit_c;
  logic       emit_l, emit_d;
  logic       ofree;
  assign ofree = !ov_q || out_m.ready;
  assign out_m.valid     = ov_q;
  assign out_m.out_char  = oc_q;
  assign out_m.run_last  = ol_q;
  assign out_m.para_done = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (emit) ov_q <= 1'b1;
    else if (out_m.ready) ov_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (emit) begin
      oc_q <= emit_c;
      ol_q <= emit_l;
      od_q <= emit_d;
    end
  end

  // Memory.
  logic       we;
  logic [4:0] waddr, raddr;
  logic [7:0] wdata, rdata;
  glj_store u_store (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Divider.
  logic       dstart, dbusy;
  logic [5:0] dnum, dquo;
  logic [4:0] dden, drem;
  glj_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(dstart), .num_i(dnum),
    .den_i(dden), .busy_o(dbusy), .quo_o(dquo), .rem_o(drem)
  );
  assign dden = spaces_q - 5'd1;
  assign dnum = 6'(w) - (6'(last_q) - 6'(dden));

  // Line end position of current emit walk.
  logic [5:0] walk_end;
  always_comb begin
    case (mode_q)
      glj_pkg::ModePlain:  walk_end = 6'(w);
      glj_pkg::ModeHyphen: walk_end = 6'(w) - 6'd1;
      default:             walk_end = 6'(last_q);
    endcase
  end
  logic [5:0] remain;
  assign remain = fill_q - used_q;

  assign in_s.ready = (state_q == glj_pkg::StIdle) && !cfg_wr;

  always_comb begin
    state_d = state_q; fill_d = fill_q; end_d = end_q; idx_d = idx_q;
    dst_d = dst_q; spaces_d = spaces_q; last_d = last_q; mode_d = mode_q;
    used_d = used_q; qcnt_d = qcnt_q; rcnt_d = rcnt_q;
    we = 1'b0; waddr = fill_q[4:0]; wdata = in_s.in_char; raddr = idx_q[4:0];
    emit = 1'b0; emit_c = rdata; emit_l = 1'b0; emit_d = 1'b0; dstart = 1'b0;
    case (state_q)
      glj_pkg::StIdle: begin
        if (in_s.valid && in_s.ready) begin
          we = 1'b1;
          end_d = in_s.para_end;
          fill_d = fill_q + 6'd1;
          idx_d = 6'd0; dst_d = 6'd0; spaces_d = 5'd0; last_d = 5'd0;
          if (fill_q + 6'd1 >= 6'(w) + 6'd1) state_d = glj_pkg::StScanRd;
          else if (in_s.para_end) state_d = glj_pkg::StFlushRd;
        end
      end
      glj_pkg::StScanRd: state_d = glj_pkg::StScan;
      glj_pkg::StScan: begin
        // rdata is store[idx]; idx runs 0..w.
        if (idx_q == 6'(w)) begin
          if (rdata == glj_pkg::SpaceCh) begin
            mode_d = glj_pkg::ModePlain; used_d = 6'(w) + 6'd1;
          end else if (spaces_q < 5'd2) begin
            mode_d = glj_pkg::ModeHyphen; used_d = 6'(w) - 6'd1;
          end else begin
            mode_d = glj_pkg::ModeJustify; used_d = 6'(last_q) + 6'd1;
          end
          state_d = glj_pkg::StPlan;
        end else begin
          if (rdata == glj_pkg::SpaceCh) begin
            spaces_d = spaces_q + 5'd1; last_d = idx_q[4:0];
          end
          idx_d = idx_q + 6'd1;
          state_d = glj_pkg::StScanRd;
        end
      end
      glj_pkg::StPlan: begin
        // In justify mode start the divider once, then wait for it.
        if (mode_q == glj_pkg::ModeJustify && dst_q == 6'd0) begin
          dstart = 1'b1; dst_d = 6'd1;
        end else if (!dbusy) begin
          qcnt_d = dquo; rcnt_d = drem; dst_d = 6'd0; idx_d = 6'd0;
          state_d = glj_pkg::StEmitRd;
        end
      end
      glj_pkg::StEmitRd: begin
        if (idx_q == walk_end) begin
          state_d = (mode_q == glj_pkg::ModeHyphen) ? glj_pkg::StPad
                                                    : glj_pkg::StNewline;
        end else begin
          state_d = glj_pkg::StEmit;
        end
      end
      glj_pkg::StEmit: begin
        if (ofree) begin
          if (mode_q == glj_pkg::ModeJustify && rdata == glj_pkg::SpaceCh) begin
            dst_d = 6'd0; state_d = glj_pkg::StPad;
          end else begin
            emit = 1'b1;
            idx_d = idx_q + 6'd1; state_d = glj_pkg::StEmitRd;
          end
        end
      end
      glj_pkg::StPad: begin
        // Hyphen mode: one hyphen. Justify: q spaces plus one while r > 0.
        if (ofree) begin
          if (mode_q == glj_pkg::ModeHyphen) begin
            emit = 1'b1; emit_c = glj_pkg::HyphenCh;
            state_d = glj_pkg::StNewline;
          end else if (dst_q < qcnt_q) begin
            emit = 1'b1; emit_c = glj_pkg::SpaceCh; dst_d = dst_q + 6'd1;
          end else if (rcnt_q != 5'd0) begin
            emit = 1'b1; emit_c = glj_pkg::SpaceCh; rcnt_d = rcnt_q - 5'd1;
            idx_d = idx_q + 6'd1; state_d = glj_pkg::StEmitRd;
          end else begin
            idx_d = idx_q + 6'd1; state_d = glj_pkg::StEmitRd;
          end
        end
      end
      glj_pkg::StNewline: begin
        if (ofree) begin
          emit = 1'b1; emit_c = glj_pkg::NewlineCh;
          if (remain == 6'd0 || !end_q) begin
            emit_l = 1'b1; emit_d = end_q;
          end
          fill_d = remain;
          idx_d = used_q; dst_d = 6'd0;
          state_d = (remain == 6'd0) ? glj_pkg::StIdle : glj_pkg::StMoveRd;
        end
      end
      glj_pkg::StMoveRd: begin
        if (dst_q == fill_q) begin
          idx_d = 6'd0;
          state_d = end_q ? glj_pkg::StFlushRd : glj_pkg::StIdle;
        end else begin
          state_d = glj_pkg::StMove;
        end
      end
      glj_pkg::StMove: begin
        we = 1'b1; waddr = dst_q[4:0]; wdata = rdata;
        dst_d = dst_q + 6'd1; idx_d = idx_q + 6'd1;
        state_d = glj_pkg::StMoveRd;
      end
      glj_pkg::StFlushRd: begin
        if (idx_q == fill_q) begin
          fill_d = 6'd0; state_d = glj_pkg::StIdle;
        end else begin
          state_d = glj_pkg::StFlush;
        end
      end
      glj_pkg::StFlush: begin
        if (ofree) begin
          emit = 1'b1;
          emit_l = (idx_q + 6'd1 == fill_q);
          emit_d = emit_l;
          idx_d = idx_q + 6'd1; state_d = glj_pkg::StFlushRd;
        end
      end
      default: state_d = glj_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= glj_pkg::StIdle;
      fill_q <= 6'd0; end_q <= 1'b0; idx_q <= 6'd0; dst_q <= 6'd0;
      spaces_q <= 5'd0; last_q <= 5'd0; mode_q <= glj_pkg::ModePlain;
      used_q <= 6'd0; qcnt_q <= 6'd0; rcnt_q <= 5'd0;
      width_q <= 5'd31;
    end else begin
      state_q <= state_d; end_q <= end_d; idx_q <= idx_d;
      dst_q <= dst_d; spaces_q <= spaces_d; last_q <= last_d; mode_q <= mode_d;
      used_q <= used_d; qcnt_q <= qcnt_d; rcnt_q <= rcnt_d;
      if (cfg_wr) begin
        width_q <= pwdata[4:0];
        fill_q <= 6'd0;
      end else begin
        fill_q <= fill_d;
      end
    end
  end
endmodule
`default_nettype wire

// ----- test/tb_glj_if.sv -----
// Testbench copies of nothing: the stream interfaces come from the RTL file glj_if.sv.
// This file holds the small shared item type used by the testbench; depends on nothing.
package tb_glj_pkg;
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } glj_res_t;
endpackage

// ----- test/tb_greedy_line_justifier.sv -----
// Testbench for greedy_line_justifier: drives paragraph characters, writes the
// width register over APB and checks every output character against a predictor.
// Depends on glj_pkg, glj_if, tb_glj_pkg and the RTL.
module tb_greedy_line_justifier;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  glj_in_if in_s ();
  glj_out_if out_m ();

  greedy_line_justifier dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_s.sink), .out_m(out_m.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: its own copy of the held text and the width register.
  logic [7:0] held_text [32];
  int unsigned held_cnt;
  logic [4:0] width_reg;
  tb_glj_pkg::glj_res_t expected_chars [$];
  int errors = 0;
  longint cycles = 0;
  bit rx_calm = 0;       // long stretch with no receiver idling
  bit rx_hold = 0;       // long receiver hold-off
  bit hold_go = 0;       // sender asks for the hold-off while it keeps sending
  bit tx_calm = 0;

  function automatic int unsigned line_width();
    int unsigned w;
    w = width_reg;
    if (w < 2) w = 2;
    if (w > 31) w = 31;
    return w;
  endfunction

  function automatic void push_char(logic [7:0] c);
    tb_glj_pkg::glj_res_t r;
    r.ch = c;
    r.last = 1'b0;
    r.done = 1'b0;
    expected_chars = {expected_chars, r};
  endfunction

  // Emits one justified line from the held text and returns the count consumed.
  function automatic int unsigned justify_line(int unsigned w);
    int unsigned spaces, last_sp, gaps, extra, q, r, used;
    spaces = 0;
    last_sp = 0;
    if (held_text[w] == glj_pkg::SpaceCh) begin
      for (int i = 0; i < w; i++) push_char(held_text[i]);
      used = w + 1;
    end else begin
      for (int i = 0; i < w; i++) begin
        if (held_text[i] == glj_pkg::SpaceCh) begin
          spaces++;
          last_sp = i;
        end
      end
      if (spaces < 2) begin
        for (int i = 0; i + 1 < w; i++) push_char(held_text[i]);
        push_char(glj_pkg::HyphenCh);
        used = w - 1;
      end else begin
        gaps = spaces - 1;
        extra = w - (last_sp - gaps);
        q = extra / gaps;
        r = extra % gaps;
        for (int i = 0; i < last_sp; i++) begin
          if (held_text[i] == glj_pkg::SpaceCh) begin
            for (int k = 0; k < q; k++) push_char(glj_pkg::SpaceCh);
            if (r > 0) begin
              push_char(glj_pkg::SpaceCh);
              r--;
            end
          end else begin
            push_char(held_text[i]);
          end
        end
        used = last_sp + 1;
      end
    end
    push_char(glj_pkg::NewlineCh);
    return used;
  endfunction

  // Works out the output characters caused by one accepted input character.
  function automatic void predict_char(logic [7:0] c, logic pend);
    int unsigned w, used, before_cnt;
    w = line_width();
    before_cnt = expected_chars.size();
    if (held_cnt < 32) begin
      held_text[held_cnt] = c;
      held_cnt++;
    end
    if (held_cnt >= w + 1) begin
      used = justify_line(w);
      if (used > held_cnt) used = held_cnt;
      for (int i = 0; i < held_cnt - used; i++) held_text[i] = held_text[i + used];
      held_cnt -= used;
    end
    if (pend) begin
      for (int i = 0; i < held_cnt; i++) push_char(held_text[i]);
      held_cnt = 0;
    end
    if (expected_chars.size() > before_cnt) begin
      expected_chars[$].last = 1'b1;
      expected_chars[$].done = pend;
    end
  endfunction

  // Input channel driver. Valid stays high between back-to-back transfers; ready
  // is sampled at the falling edge so the transfer edge is known exactly.
  task automatic send_char(logic [7:0] c, logic pend);
    int gap;
    bit ok;
    gap = 0;
    if (!tx_calm) begin
      while ($urandom_range(99) < 19) gap++;
    end
    if (gap > 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_s.valid <= 1'b1;
    in_s.in_char <= c;
    in_s.para_end <= pend;
    ok = 1'b0;
    while (!ok) begin
      @(negedge clk_i);
      ok = in_s.ready;
      @(posedge clk_i);
    end
    predict_char(c, pend);
  endtask

  task automatic wait_drained();
    in_s.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(glj_pkg::RegWidth) * 4) begin
      width_reg = data[4:0];
      held_cnt = 0;
    end
    @(posedge clk_i);
  endtask

  // Random word-like text: letters with spaces, any byte now and then.
  function automatic logic [7:0] text_char();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 22) return glj_pkg::SpaceCh;
    if (p < 85) return 8'($urandom_range(97, 122));
    return 8'($urandom_range(255));
  endfunction

  // Directed table: character, paragraph end.
  typedef struct {
    logic [7:0] ch;
    logic       pend;
  } stim_t;
  stim_t directed [20] = '{
    '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{glj_pkg::SpaceCh, 1'b1},
    '{8'h61, 1'b0}, '{glj_pkg::SpaceCh, 1'b0}, '{8'h62, 1'b0}, '{8'h63, 1'b0},
    '{8'h64, 1'b1},
    '{8'h61, 1'b0}, '{glj_pkg::SpaceCh, 1'b0}, '{8'h62, 1'b0},
    '{glj_pkg::SpaceCh, 1'b0},
    '{8'h63, 1'b0}, '{8'h64, 1'b0}, '{8'h65, 1'b1},
    '{8'h78, 1'b0}, '{8'h79, 1'b0}, '{8'h7A, 1'b0}, '{8'h77, 1'b0}, '{8'h76, 1'b0}
  };

  logic [4:0] widths [7] = '{5'd31, 5'd2, 5'd0, 5'd1, 5'd7, 5'd15, 5'd31};

  // Output checker: compares each transfer with the oldest expectation.
  always @(posedge clk_i) begin
    tb_glj_pkg::glj_res_t e;
    cycles <= cycles + 1;
    if (rst_ni && out_m.valid && out_m.ready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected output transfer, out_char=%0d", out_m.out_char);
        errors++;
      end else begin
        e = expected_chars.pop_front();
        if (out_m.out_char !== e.ch) begin
          $error("out_char expected %0d actual %0d", e.ch, out_m.out_char);
          errors++;
        end
        if (out_m.run_last !== e.last) begin
          $error("run_last expected %0d actual %0d", e.last, out_m.run_last);
          errors++;
        end
        if (out_m.para_done !== e.done) begin
          $error("para_done expected %0d actual %0d", e.done, out_m.para_done);
          errors++;
        end
      end
    end
  end

  // Receiver stall pattern, with a calm stretch and a long hold-off.
  always @(posedge clk_i) begin
    if (rx_hold) out_m.ready <= 1'b0;
    else if (rx_calm) out_m.ready <= 1'b1;
    else out_m.ready <= ($urandom_range(99) >= 19);
  end

  // Long receiver hold-off counted in its own process.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1;
    repeat (400) @(posedge clk_i);
    rx_hold = 0;
  end

  initial begin
    wait (cycles == 2000000);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    in_s.valid = 1'b0;
    in_s.in_char = '0;
    in_s.para_end = 1'b0;
    out_m.ready = 1'b0;
    held_cnt = 0;
    width_reg = 5'd31;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset width, then again at a narrow width, so
    // hyphenation and gap widening occur.
    foreach (directed[i]) send_char(directed[i].ch, directed[i].pend);
    wait_drained();
    apb_write(3'd4, 32'd3);        // ignored: no register there
    apb_write(3'd0, 32'd4);
    foreach (directed[i]) send_char(directed[i].ch, directed[i].pend);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b0);
    send_char(8'h63, 1'b0);
    send_char(8'h64, 1'b0);        // remainder of exactly width ends paragraph
    send_char(8'h65, 1'b1);
    wait_drained();

    // Random phases over several widths, extremes among them.
    foreach (widths[p]) begin
      apb_write(3'd0, {27'($urandom), widths[p]});
      tx_calm = (p == 2);
      rx_calm = (p == 4);
      for (int n = 0; n < 54; n++) begin
        send_char(text_char(), ($urandom_range(99) < 6) || n == 53);
        if (p == 1 && n == 10) hold_go = 1;     // receiver holds off, sender goes on
        if (p == 3 && n == 20) wait_drained();  // sender pause until drained
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
